[rtl/clock_buffer_cache_controller_defines.svh]
// Assertion macros for the clock buffer cache controller
`ifndef CLOCK_BUFFER_CACHE_CONTROLLER_DEFINES_SVH
`define CLOCK_BUFFER_CACHE_CONTROLLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define CBC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CBC_ASSERT_IMP(label, clk, rst, ante, cons)
`define CBC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/cbc_pkg.sv]
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and codes of the clock buffer cache controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int SLOTS = 64;

  localparam logic [1:0] MODE_ACQUIRE = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_FLUSH   = 2'd2;

  localparam logic [2:0] ST_HIT         = 3'd0;
  localparam logic [2:0] ST_MISS        = 3'd1;
  localparam logic [2:0] ST_ALL_PINNED  = 3'd2;
  localparam logic [2:0] ST_SLOT_PINNED = 3'd3;
  localparam logic [2:0] ST_RELEASED    = 3'd4;
  localparam logic [2:0] ST_FLUSH_WRITE = 3'd5;
  localparam logic [2:0] ST_FLUSH_NONE  = 3'd6;
  localparam logic [2:0] ST_BAD_RELEASE = 3'd7;

  localparam int FLUSH_CAP = 64;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;      // capture the request
    logic scan_clr;   // reset scan index
    logic scan_step;  // advance scan index
    logic sweep_step; // clear ref mark at pointer, advance pointer
    logic do_hit;     // pin the matching slot
    logic do_miss;    // install at pointer
    logic do_release; // release the requested slot
    logic do_flush;   // clear dirty at scan index
    logic tag_rd;     // read tag at the chosen address
  } cbc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] mode;
    logic       any_free;
    logic       scan_match;   // valid entry at scan index holds the sector
    logic       scan_flush;   // scan index valid, dirty, unpinned
    logic       scan_end;     // scan index is the last slot
    logic       scan_pinned;
    logic       ptr_busy;     // pointer slot referenced or pinned
    logic       rel_ok;
    logic       flush_more;   // a flushable slot lies beyond the scan index
  } cbc_stat_t;

endpackage

[rtl/cbc_stream_if.sv]
// ----------------------------------------------------------------------------
// cbc_stream_if
// Valid/ready channel carrying a payload type.
// ----------------------------------------------------------------------------
interface cbc_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/clock_buffer_cache_controller.sv]
// ----------------------------------------------------------------------------
// clock_buffer_cache_controller
// Clock second-chance tag and policy controller for a 64-slot sector cache.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req (mode, sector, slot, mark_dirty); results leave
// on rsp (status, slot_out, victim fields, last). One request at a time: req is
// ready only when the previous request has delivered its last result.
// A release is checked and answered directly; an acquire scans the slots in
// order until one holds the sector (a hit); a miss scans every slot, then moves
// the sweep pointer past referenced or pinned slots and installs at the first
// free one. A flush scans every slot and writes each valid, dirty, unpinned one.
// The tag memory is read one slot at a time through its registered read ports.
// Reset clears all marks and the sweep pointer; no clearing pass is needed.
// A stalled rsp holds its transaction and the block waits.
// The final flush write carries last; a flush with nothing to write answers
// flush none.
// ----------------------------------------------------------------------------
module clock_buffer_cache_controller (
  input logic clk,
  input logic rst,
  cbc_stream_if.sink   req,
  cbc_stream_if.source rsp
);
  cbc_pkg::cbc_cmd_t  cmd;
  cbc_pkg::cbc_stat_t stat;
  logic [5:0]  scan_slot, ptr_slot, req_slot;
  logic [31:0] tag_q;
  logic        ptr_valid, ptr_dirty;

  cbc_datapath u_dp (
    .clk, .rst, .cmd, .stat,
    .in_mode(req.data.mode), .in_sector(req.data.sector),
    .in_slot(req.data.slot), .in_mark_dirty(req.data.mark_dirty),
    .scan_slot, .ptr_slot, .req_slot, .tag_q, .ptr_valid, .ptr_dirty
  );

  cbc_controller u_ctl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready), .in_mode(req.data.mode),
    .cmd, .stat, .scan_slot, .ptr_slot, .req_slot, .tag_q, .ptr_valid, .ptr_dirty,
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .o_status(rsp.data.status), .o_slot(rsp.data.slot_out),
    .o_vvalid(rsp.data.victim_valid), .o_vsector(rsp.data.victim_sector),
    .o_vdirty(rsp.data.victim_dirty), .o_last(rsp.data.last)
  );
endmodule

[rtl/cbc_datapath.sv]
// ----------------------------------------------------------------------------
// cbc_datapath
// Tag memory, policy marks, scan index and sweep pointer.
// ----------------------------------------------------------------------------
module cbc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  cbc_pkg::cbc_cmd_t   cmd,
  output cbc_pkg::cbc_stat_t  stat,
  input  logic [1:0]          in_mode,
  input  logic [31:0]         in_sector,
  input  logic [5:0]          in_slot,
  input  logic                in_mark_dirty,
  output logic [5:0]          scan_slot,
  output logic [5:0]          ptr_slot,
  output logic [5:0]          req_slot,
  output logic [31:0]         tag_q,
  output logic                ptr_valid,
  output logic                ptr_dirty
);
  localparam int SLOTS = cbc_pkg::SLOTS;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [31:0]   tag_mem [SLOTS];
  logic [SLOTS-1:0] valid_m, dirty_m, ref_m, pin_m;
  logic [SLOTS-1:0] flush_m;
  logic [IW-1:0] scan, ptr;
  logic [1:0]    mode;
  logic [31:0]   sector;
  logic [5:0]    rslot;
  logic          mdirty;
  logic [31:0]   scan_tag;
  logic [IW-1:0] rel_idx;
  logic          rel_in_range;

  assign rel_idx      = rslot[IW-1:0];
  assign rel_in_range = ({26'd0, rslot} < 32'(SLOTS));

  // Slots that a flush would write back
  assign flush_m = valid_m & dirty_m & ~pin_m;

  // Capture request
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode   <= in_mode;
      sector <= in_sector;
      rslot  <= in_slot;
      mdirty <= in_mark_dirty;
    end
  end

  // Tag memory: one write port, two registered read ports (tag_q and scan_tag)
  always_ff @(posedge clk) begin
    if (cmd.do_miss) begin
      tag_mem[ptr] <= sector;
    end
    if (cmd.tag_rd) begin
      tag_q <= tag_mem[cmd.do_flush || cmd.scan_step ? scan : ptr];
    end
    scan_tag <= tag_mem[scan];
  end

  // Marks, scan index and sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_m <= '0;
      dirty_m <= '0;
      ref_m   <= '0;
      pin_m   <= '0;
      ptr     <= '0;
      scan    <= '0;
    end else begin
      if (cmd.scan_clr) begin
        scan <= '0;
      end else if (cmd.scan_step) begin
        scan <= (32'(scan) == SLOTS - 1) ? '0 : scan + 1'b1;
      end
      if (cmd.sweep_step) begin
        ref_m[ptr] <= 1'b0;
        ptr <= (32'(ptr) == SLOTS - 1) ? '0 : ptr + 1'b1;
      end
      if (cmd.do_hit) begin
        pin_m[scan] <= 1'b1;
      end
      if (cmd.do_miss) begin
        valid_m[ptr] <= 1'b1;
        dirty_m[ptr] <= 1'b0;
        pin_m[ptr]   <= 1'b1;
        ptr <= (32'(ptr) == SLOTS - 1) ? '0 : ptr + 1'b1;
      end
      if (cmd.do_release) begin
        if (mdirty) dirty_m[rel_idx] <= 1'b1;
        ref_m[rel_idx] <= 1'b1;
        pin_m[rel_idx] <= 1'b0;
      end
      if (cmd.do_flush) begin
        dirty_m[scan] <= 1'b0;
      end
    end
  end

  // Status; scan_tag is registered from scan, controller waits for it
  always_comb begin
    stat.mode        = mode;
    stat.any_free    = ~&pin_m;
    stat.scan_match  = valid_m[scan] && (scan_tag == sector);
    stat.scan_flush  = valid_m[scan] && dirty_m[scan] && !pin_m[scan];
    stat.scan_end    = (32'(scan) == SLOTS - 1);
    stat.scan_pinned = pin_m[scan];
    stat.ptr_busy    = ref_m[ptr] || pin_m[ptr];
    stat.rel_ok      = rel_in_range && pin_m[rel_idx];
    stat.flush_more  = |((flush_m >> scan) >> 1);
  end

  assign scan_slot = 6'(scan);
  assign ptr_slot  = 6'(ptr);
  assign req_slot  = rslot;
  assign ptr_valid = valid_m[ptr];
  assign ptr_dirty = dirty_m[ptr];
endmodule

[rtl/cbc_controller.sv]
// ----------------------------------------------------------------------------
// cbc_controller
// Sequencer for acquire, release and flush; builds the result transactions.
// ----------------------------------------------------------------------------
`include "clock_buffer_cache_controller_defines.svh"
module cbc_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  output cbc_pkg::cbc_cmd_t  cmd,
  input  cbc_pkg::cbc_stat_t stat,
  input  logic [5:0]         scan_slot,
  input  logic [5:0]         ptr_slot,
  input  logic [5:0]         req_slot,
  input  logic [31:0]        tag_q,
  input  logic               ptr_valid,
  input  logic               ptr_dirty,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         o_status,
  output logic [5:0]         o_slot,
  output logic               o_vvalid,
  output logic [31:0]        o_vsector,
  output logic               o_vdirty,
  output logic               o_last
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_LOOKW  = 9'b000000100,
    S_LOOK   = 9'b000001000,
    S_SWEEP  = 9'b000010000,
    S_FLUSHW = 9'b000100000,
    S_FLUSH  = 9'b001000000,
    S_FTAG   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   fin;        // request ends after this result
  logic   pending;    // flush result waiting for tag
  logic   any_sent;
  logic   miss_pend;
  logic [2:0]  r_status;
  logic [5:0]  r_slot;
  logic        r_vvalid, r_vdirty;
  logic [6:0]  nsent;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next = (in_mode == cbc_pkg::MODE_ACQUIRE || in_mode == cbc_pkg::MODE_RELEASE
                        || in_mode == cbc_pkg::MODE_FLUSH) ? S_DECODE : S_IDLE;
        end
      end
      S_DECODE: begin
        unique case (stat.mode)
          cbc_pkg::MODE_ACQUIRE: state_next = stat.any_free ? S_LOOKW : S_OUT;
          cbc_pkg::MODE_RELEASE: begin
            cmd.do_release = stat.rel_ok;
            state_next = S_OUT;
          end
          default: state_next = S_FLUSHW;
        endcase
      end
      S_LOOKW: state_next = S_LOOK;
      S_LOOK: begin
        if (stat.scan_match) begin
          cmd.do_hit = !stat.scan_pinned;
          state_next = S_OUT;
        end else if (stat.scan_end) begin
          state_next = S_SWEEP;
        end else begin
          cmd.scan_step = 1'b1;
          state_next = S_LOOKW;
        end
      end
      S_SWEEP: begin
        if (stat.ptr_busy) begin
          cmd.sweep_step = 1'b1;
        end else begin
          cmd.tag_rd = 1'b1;
          state_next = S_FTAG;
        end
      end
      S_FLUSHW: state_next = S_FLUSH;
      S_FLUSH: begin
        if (stat.scan_flush && nsent < 7'(cbc_pkg::FLUSH_CAP)) begin
          cmd.tag_rd = 1'b1;
          cmd.do_flush = 1'b1;
          state_next = S_FTAG;
        end else if (stat.scan_end) begin
          state_next = any_sent ? S_IDLE : S_OUT;
        end else begin
          cmd.scan_step = 1'b1;
          state_next = S_FLUSHW;
        end
      end
      S_FTAG: begin
        cmd.do_miss = miss_pend;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_valid && out_ready) begin
          if (fin) begin
            state_next = S_IDLE;
          end else begin
            cmd.scan_step = 1'b1;
            state_next = S_FLUSHW;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Result registers: build on entry to S_OUT
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      any_sent  <= 1'b0;
      miss_pend <= 1'b0;
      pending   <= 1'b0;
      nsent     <= '0;
      fin       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        any_sent <= 1'b0;
        nsent    <= '0;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_DECODE) begin
        r_vvalid <= 1'b0;
        r_vdirty <= 1'b0;
        if (stat.mode == cbc_pkg::MODE_ACQUIRE) begin
          r_status <= cbc_pkg::ST_ALL_PINNED;
          r_slot <= '0;
          fin <= 1'b1;
          out_valid <= !stat.any_free;
          o_vsector <= '0;
        end else if (stat.mode == cbc_pkg::MODE_RELEASE) begin
          r_status <= stat.rel_ok ? cbc_pkg::ST_RELEASED : cbc_pkg::ST_BAD_RELEASE;
          r_slot <= req_slot;
          fin <= 1'b1;
          out_valid <= 1'b1;
          o_vsector <= '0;
        end
      end
      if (state == S_LOOK && stat.scan_match) begin
        r_status  <= stat.scan_pinned ? cbc_pkg::ST_SLOT_PINNED : cbc_pkg::ST_HIT;
        r_slot    <= scan_slot;
        out_valid <= 1'b1;
        o_vsector <= '0;
      end
      if (state == S_SWEEP && !stat.ptr_busy) begin
        miss_pend <= 1'b1;
        pending   <= 1'b0;
        r_status  <= cbc_pkg::ST_MISS;
        r_slot    <= ptr_slot;
        r_vvalid  <= ptr_valid;
        r_vdirty  <= ptr_valid && ptr_dirty;
      end
      if (state == S_FLUSH) begin
        if (stat.scan_flush && nsent < 7'(cbc_pkg::FLUSH_CAP)) begin
          pending  <= 1'b1;
          r_status <= cbc_pkg::ST_FLUSH_WRITE;
          r_slot   <= scan_slot;
          r_vvalid <= 1'b1;
          r_vdirty <= 1'b1;
          any_sent <= 1'b1;
          nsent    <= nsent + 7'd1;
        end else if (stat.scan_end && !any_sent) begin
          r_status  <= cbc_pkg::ST_FLUSH_NONE;
          r_slot    <= '0;
          r_vvalid  <= 1'b0;
          r_vdirty  <= 1'b0;
          o_vsector <= '0;
          fin       <= 1'b1;
          out_valid <= 1'b1;
        end
      end
      if (state == S_FTAG) begin
        miss_pend <= 1'b0;
        pending   <= 1'b0;
        o_vsector <= r_vvalid ? tag_q : '0;
        out_valid <= 1'b1;
        fin       <= miss_pend || !stat.flush_more || (nsent == 7'(cbc_pkg::FLUSH_CAP)) ||
                     !pending;
      end
    end
  end

  // Last mark: set on the final result of a request; on a flush write, when no later write follows
  assign o_status = r_status;
  assign o_slot   = r_slot;
  assign o_vvalid = r_vvalid;
  assign o_vdirty = r_vdirty;
  assign o_last   = fin;

  `CBC_ASSERT_IMP(a_out_in_state, clk, rst, out_valid, state == S_OUT)
  `CBC_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, !out_valid)
  `CBC_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(o_status))
endmodule
